[hdl/vlsu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlsu_pkg: shared types, codes and helpers
// Request and result layouts, opcodes and byte-lane helper functions for the
// vector load/store lane unit.
// ----------------------------------------------------------------------------
package vlsu_pkg;

    localparam int QDEPTH = 4;

    // instruction codes
    localparam logic [3:0] MODE_VLEB  = 4'd0;
    localparam logic [3:0] MODE_VLEH  = 4'd1;
    localparam logic [3:0] MODE_VLEG  = 4'd2;
    localparam logic [3:0] MODE_VLEF  = 4'd3;
    localparam logic [3:0] MODE_VLLEZ = 4'd4;
    localparam logic [3:0] MODE_VLREP = 4'd5;
    localparam logic [3:0] MODE_VL    = 4'd6;
    localparam logic [3:0] MODE_VLBB  = 4'd7;
    localparam logic [3:0] MODE_VSTEB = 4'd8;
    localparam logic [3:0] MODE_VSTEH = 4'd9;
    localparam logic [3:0] MODE_VSTEG = 4'd10;
    localparam logic [3:0] MODE_VSTEF = 4'd11;
    localparam logic [3:0] MODE_VST   = 4'd12;
    localparam logic [3:0] MODE_LCBB  = 4'd13;
    localparam logic [3:0] MODE_VGBM  = 4'd14;
    localparam logic [3:0] MODE_VN    = 4'd15;

    // exception codes
    localparam logic [1:0] EXC_NONE = 2'd0;
    localparam logic [1:0] EXC_SPEC = 2'd1;
    localparam logic [1:0] EXC_DIS  = 2'd2;

    // condition codes
    localparam logic [1:0] CC_FULL  = 2'd0;
    localparam logic [1:0] CC_SHORT = 2'd3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [4:0]  target_reg;
        logic [4:0]  source_a_reg;
        logic [4:0]  source_b_reg;
        logic [3:0]  element_code;
        logic [11:0] address_offset;
        logic [15:0] immediate_mask;
        logic [63:0] memory_high;
        logic [63:0] memory_low;
    } req_t;

    typedef struct packed {
        logic [63:0] store_high;
        logic [63:0] store_low;
        logic [4:0]  store_length;
        logic [4:0]  fetch_length;
        logic [4:0]  boundary_count;
        logic [1:0]  cond_code;
        logic        cond_code_valid;
        logic [1:0]  exception_code;
    } rsp_t;

    // decoded operation passed from front to back
    typedef struct packed {
        logic [1:0]   exc;
        logic [4:0]   rd_a;
        logic [4:0]   rd_b;
        logic         is_vn;
        logic         wr_en;
        logic [4:0]   wr_addr;
        logic [15:0]  wr_be;
        logic [127:0] wr_data;
        logic [3:0]   st_pos;
        logic [4:0]   st_len;
        logic [4:0]   fetch_len;
        logic [4:0]   bcount;
        logic [1:0]   cc;
        logic         ccv;
    } op_t;

    // front to back handshake
    typedef struct packed {
        logic valid;
        op_t  op;
    } issue_t;

    // expand byte enables (bit 15 = byte 0) to bit mask
    function automatic logic [127:0] be_bits(logic [15:0] be);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = {8{be[15-i]}};
        end
        return r;
    endfunction

    // enables for the leading len bytes
    function automatic logic [15:0] lead_be(logic [4:0] len);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[15-i] = (5'(i) < len);
        end
        return r;
    endfunction

    // bytes to the block boundary, capped at sixteen
    function automatic logic [4:0] block_count(logic [2:0] code, logic [11:0] addr);
        logic [12:0] bnd;
        logic [12:0] n;
        bnd = 13'd64 << code;
        n   = bnd - ({1'b0, addr} & (bnd - 13'd1));
        return (n > 13'd16) ? 5'd16 : n[4:0];
    endfunction

endpackage
`default_nettype wire

[hdl/vlsu_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlsu_front: request decode and operation queue
// Classifies each request into byte-lane writes, reads and result fields and
// holds the decoded operations in a short queue for the back end.
// ----------------------------------------------------------------------------
module vlsu_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           vec_en,
    input  wire vlsu_pkg::req_t req,
    input  wire logic           push,
    output logic                full,
    output vlsu_pkg::issue_t    issue,
    input  wire logic           take
);

    vlsu_pkg::op_t op;
    vlsu_pkg::op_t q_reg [vlsu_pkg::QDEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    logic [127:0] mem;
    logic [3:0]   m3;
    logic [4:0]   len;
    logic [1:0]   lg;
    logic [3:0]   pos;
    logic [3:0]   emax;
    logic [127:0] rep;

    // decode
    always_comb
    begin
        mem = {req.memory_high, req.memory_low};
        m3  = req.element_code;
        op  = '0;
        op.wr_addr = req.target_reg;
        op.rd_a    = req.target_reg;
        op.rd_b    = req.source_b_reg;
        case (req.mode[1:0])
            2'd0:    begin lg = 2'd0; emax = 4'd15; end
            2'd1:    begin lg = 2'd1; emax = 4'd7;  end
            2'd2:    begin lg = 2'd3; emax = 4'd1;  end
            default: begin lg = 2'd2; emax = 4'd3;  end
        endcase
        len = 5'd1 << lg;
        pos = m3 << lg;
        for (int i = 0; i < 16; i++)
        begin
            rep[127-8*i -: 8] = mem[127-8*(32'(i) & (32'(len) - 1)) -: 8];
        end

        if (!vec_en)
        begin
            op.exc = vlsu_pkg::EXC_DIS;
        end
        else
        begin
            case (req.mode)
                vlsu_pkg::MODE_VLEB, vlsu_pkg::MODE_VLEH,
                vlsu_pkg::MODE_VLEG, vlsu_pkg::MODE_VLEF:
                begin
                    if (m3 > emax)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        op.wr_en     = 1'b1;
                        op.wr_be     = vlsu_pkg::lead_be(len) >> pos;
                        op.wr_data   = mem >> {pos, 3'b000};
                        op.fetch_len = len;
                    end
                end
                vlsu_pkg::MODE_VSTEB, vlsu_pkg::MODE_VSTEH,
                vlsu_pkg::MODE_VSTEG, vlsu_pkg::MODE_VSTEF:
                begin
                    if (m3 > emax)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        op.st_pos = pos;
                        op.st_len = len;
                    end
                end
                vlsu_pkg::MODE_VLLEZ:
                begin
                    if (m3 > 4'd3 && m3 != 4'd6)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        if (m3 == 4'd6)
                        begin
                            len = 5'd4;
                            pos = 4'd0;
                        end
                        else
                        begin
                            len = 5'd1 << m3[1:0];
                            pos = 4'd8 - len[3:0];
                        end
                        op.wr_en     = 1'b1;
                        op.wr_be     = 16'hffff;
                        op.wr_data   = (mem & vlsu_pkg::be_bits(vlsu_pkg::lead_be(len)))
                                       >> {pos, 3'b000};
                        op.fetch_len = len;
                    end
                end
                vlsu_pkg::MODE_VLREP:
                begin
                    if (m3 > 4'd3)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        len = 5'd1 << m3[1:0];
                        for (int i = 0; i < 16; i++)
                        begin
                            rep[127-8*i -: 8] = mem[127-8*(32'(i) & (32'(len) - 1)) -: 8];
                        end
                        op.wr_en     = 1'b1;
                        op.wr_be     = 16'hffff;
                        op.wr_data   = rep;
                        op.fetch_len = len;
                    end
                end
                vlsu_pkg::MODE_VL:
                begin
                    op.wr_en     = 1'b1;
                    op.wr_be     = 16'hffff;
                    op.wr_data   = mem;
                    op.fetch_len = 5'd16;
                end
                vlsu_pkg::MODE_VLBB:
                begin
                    if (m3 > 4'd6)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        len          = vlsu_pkg::block_count(m3[2:0], req.address_offset);
                        op.wr_en     = 1'b1;
                        op.wr_be     = vlsu_pkg::lead_be(len);
                        op.wr_data   = mem;
                        op.fetch_len = len;
                    end
                end
                vlsu_pkg::MODE_VST:
                begin
                    op.st_len = 5'd16;
                end
                vlsu_pkg::MODE_LCBB:
                begin
                    if (m3 > 4'd6)
                        op.exc = vlsu_pkg::EXC_SPEC;
                    else
                    begin
                        op.bcount = vlsu_pkg::block_count(m3[2:0], req.address_offset);
                        op.cc     = (op.bcount == 5'd16) ? vlsu_pkg::CC_FULL
                                                         : vlsu_pkg::CC_SHORT;
                        op.ccv    = 1'b1;
                    end
                end
                vlsu_pkg::MODE_VGBM:
                begin
                    op.wr_en   = 1'b1;
                    op.wr_be   = 16'hffff;
                    op.wr_data = vlsu_pkg::be_bits(req.immediate_mask);
                end
                default:
                begin
                    op.is_vn = 1'b1;
                    op.rd_a  = req.source_a_reg;
                    op.wr_en = 1'b1;
                    op.wr_be = 16'hffff;
                end
            endcase
        end
        // only the written lanes carry data
        op.wr_data = op.wr_data & vlsu_pkg::be_bits(op.wr_be);
    end

    // operation queue
    assign full    = (cnt_reg == 3'(vlsu_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = take && (cnt_reg != 3'd0);

    assign issue.valid = (cnt_reg != 3'd0);
    assign issue.op    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(do_push);
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        cnt_next    = cnt_reg + 3'(do_push) - 3'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= op;
    end

endmodule
`default_nettype wire

[hdl/vlsu_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlsu_back: register file and execute stage
// Reads the vector register file as an operation leaves the queue, then in
// the next cycle forms the result and writes the file with byte enables.
// ----------------------------------------------------------------------------
module vlsu_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vlsu_pkg::issue_t issue,
    output logic                  take,
    input  wire logic [2:0]       rsp_cnt,
    output logic                  rsp_push,
    output vlsu_pkg::rsp_t        rsp
);

    logic [127:0]  rf_reg [32];
    logic [31:0]   rf_valid_reg, rf_valid_next;
    logic          s1_v_reg;
    vlsu_pkg::op_t s1_reg;
    logic [127:0]  rd_a_reg, rd_b_reg;
    logic          rv_a_reg, rv_b_reg;
    logic          fwd_a_reg, fwd_b_reg;
    logic [15:0]   fwd_be_reg;
    logic [127:0]  fwd_data_reg;

    logic [127:0] ra, rb, fmask, st_data;
    logic         wr;
    logic [15:0]  be_eff;
    logic [127:0] data_eff;

    // issue only when the result queue has room for everything in flight
    assign take = issue.valid
                  && ({1'b0, rsp_cnt} + 4'(s1_v_reg) < 4'(vlsu_pkg::QDEPTH));

    // operands with bypass from the write in progress
    always_comb
    begin
        fmask = vlsu_pkg::be_bits(fwd_be_reg);
        ra = rv_a_reg ? rd_a_reg : '0;
        rb = rv_b_reg ? rd_b_reg : '0;
        if (fwd_a_reg)
            ra = (ra & ~fmask) | (fwd_data_reg & fmask);
        if (fwd_b_reg)
            rb = (rb & ~fmask) | (fwd_data_reg & fmask);
    end

    // write data; a row never written gets zeros in its other lanes
    always_comb
    begin
        wr       = s1_v_reg && s1_reg.wr_en;
        data_eff = s1_reg.is_vn ? (ra & rb) : s1_reg.wr_data;
        be_eff   = rf_valid_reg[s1_reg.wr_addr] ? s1_reg.wr_be : 16'hffff;
        rf_valid_next = rf_valid_reg;
        if (wr)
            rf_valid_next[s1_reg.wr_addr] = 1'b1;
    end

    // result
    always_comb
    begin
        st_data = (ra << {s1_reg.st_pos, 3'b000})
                  & vlsu_pkg::be_bits(vlsu_pkg::lead_be(s1_reg.st_len));
        rsp.store_high      = st_data[127:64];
        rsp.store_low       = st_data[63:0];
        rsp.store_length    = s1_reg.st_len;
        rsp.fetch_length    = s1_reg.fetch_len;
        rsp.boundary_count  = s1_reg.bcount;
        rsp.cond_code       = s1_reg.cc;
        rsp.cond_code_valid = s1_reg.ccv;
        rsp.exception_code  = s1_reg.exc;
    end
    assign rsp_push = s1_v_reg;

    // register file write
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            for (int b = 0; b < 16; b++)
            begin
                if (be_eff[15-b])
                    rf_reg[s1_reg.wr_addr][127-8*b -: 8] <= data_eff[127-8*b -: 8];
            end
        end
    end

    // register file read and stage capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_a_reg     <= rf_reg[issue.op.rd_a];
            rd_b_reg     <= rf_reg[issue.op.rd_b];
            rv_a_reg     <= rf_valid_reg[issue.op.rd_a];
            rv_b_reg     <= rf_valid_reg[issue.op.rd_b];
            fwd_a_reg    <= wr && (s1_reg.wr_addr == issue.op.rd_a);
            fwd_b_reg    <= wr && (s1_reg.wr_addr == issue.op.rd_b);
            fwd_be_reg   <= be_eff;
            fwd_data_reg <= data_eff;
            s1_reg       <= issue.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            s1_v_reg     <= take;
            rf_valid_reg <= rf_valid_next;
        end
    end

endmodule
`default_nettype wire

[hdl/vlsu_rsp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlsu_rsp_fifo: result queue
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module vlsu_rsp_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire vlsu_pkg::rsp_t din,
    input  wire logic           pop,
    output logic                empty,
    output vlsu_pkg::rsp_t      dout,
    output logic [2:0]          cnt
);

    vlsu_pkg::rsp_t q_reg [vlsu_pkg::QDEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign empty  = (cnt_reg == 3'd0);
    assign do_pop = pop && !empty;
    assign dout   = q_reg[rd_ptr_reg];
    assign cnt    = cnt_reg;

    // pointers; the back end never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(push);
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        cnt_next    = cnt_reg + 3'(push) - 3'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= din;
    end

endmodule
`default_nettype wire

[hdl/vector_load_store_lane_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vector_load_store_lane_unit_top: vector load/store lane unit
// Executes element, full and block loads and stores, generate byte mask and
// vector AND on 32 vector registers of 128 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_data with push; full high means the request is not
//   taken. Results leave on rsp_data while empty is low; pop takes one.
//   One result per request, in request order.
//   The facility-enable bit is written on cfg_valid/cfg_data (cfg_ready is
//   always high); write it only while the unit is idle.
// Timing:
//   A taken request waits in the decode queue, has the register file read as
//   it leaves, and is then executed, written and put in the result queue.
//   One request per cycle is sustained while results are popped; the
//   single-write-port register file with a bypass from the write in flight
//   sets that figure.
// Reset:
//   All registers read as zero and the facility is enabled; queues empty.
// Stall:
//   When pop stays low the four-entry result queue fills, issue stops, the
//   four-entry decode queue fills and full rises. No request is dropped.
// ----------------------------------------------------------------------------
module vector_load_store_lane_unit_top
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire vlsu_pkg::req_t req_data,
    input  wire logic           push,
    output logic                full,
    output vlsu_pkg::rsp_t      rsp_data,
    output logic                empty,
    input  wire logic           pop,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data
);

    logic             vec_en_reg, vec_en_next;
    vlsu_pkg::issue_t issue;
    logic             take;
    logic [2:0]       rsp_cnt;
    logic             rsp_push;
    vlsu_pkg::rsp_t   rsp;

    // configuration register
    assign cfg_ready   = 1'b1;
    assign vec_en_next = (cfg_valid && cfg_ready) ? cfg_data : vec_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vec_en_reg <= 1'b1;
        else
            vec_en_reg <= vec_en_next;
    end

    vlsu_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vec_en (vec_en_reg),
        .req    (req_data),
        .push   (push),
        .full   (full),
        .issue  (issue),
        .take   (take)
    );

    vlsu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .take     (take),
        .rsp_cnt  (rsp_cnt),
        .rsp_push (rsp_push),
        .rsp      (rsp)
    );

    vlsu_rsp_fifo u_rsp_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .din   (rsp),
        .pop   (pop),
        .empty (empty),
        .dout  (rsp_data),
        .cnt   (rsp_cnt)
    );

endmodule
`default_nettype wire

[tb/vector_load_store_lane_unit_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_load_store_lane_unit_top_tb: self-checking bench for the lane unit
// A queued driver pushes requests with random gaps; a monitor pops results
// with random stalls and compares every field with a behavioural predictor
// of the 32-entry vector file. The enable bit is toggled between phases.
// ----------------------------------------------------------------------------
module vector_load_store_lane_unit_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;

    logic clk;
    logic rst_n;
    vlsu_pkg::req_t req_data;
    logic push;
    logic full;
    vlsu_pkg::rsp_t rsp_data;
    logic empty;
    logic pop;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    vector_load_store_lane_unit_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .push      (push),
        .full      (full),
        .rsp_data  (rsp_data),
        .empty     (empty),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [127:0] vreg_model [32];
    logic         vec_enabled;

    vlsu_pkg::req_t pending_reqs [$];
    vlsu_pkg::rsp_t expected_rsps [$];

    int  errors;
    int  accepted_reqs;
    int  checked_rsps;
    int  idle_cycles;
    int  exc_count [3];
    int  lcbb_short;
    logic req_taken;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // byte i of a 128-bit value, byte 0 most significant
    function automatic logic [7:0] byte_at(logic [127:0] v, int i);
        return v[127 - 8*i -: 8];
    endfunction

    function automatic logic [4:0] bytes_to_boundary(logic [3:0] code, logic [11:0] addr);
        int bnd;
        int n;
        bnd = 64 << code;
        n   = bnd - (int'(addr) & (bnd - 1));
        return (n > 16) ? 5'd16 : 5'(n);
    endfunction

    // compute one expected result and update the register model
    function automatic vlsu_pkg::rsp_t execute_instr(vlsu_pkg::req_t q);
        vlsu_pkg::rsp_t r;
        logic [127:0] mem;
        logic [127:0] v;
        logic [127:0] st;
        int           esz;
        int           emax;
        int           len;
        int           pos;
        r   = '0;
        mem = {q.memory_high, q.memory_low};
        v   = vreg_model[q.target_reg];
        if (!vec_enabled)
        begin
            r.exception_code = vlsu_pkg::EXC_DIS;
            return r;
        end
        case (q.mode)
            vlsu_pkg::MODE_VLEB, vlsu_pkg::MODE_VLEH,
            vlsu_pkg::MODE_VLEG, vlsu_pkg::MODE_VLEF,
            vlsu_pkg::MODE_VSTEB, vlsu_pkg::MODE_VSTEH,
            vlsu_pkg::MODE_VSTEG, vlsu_pkg::MODE_VSTEF:
            begin
                case (q.mode[1:0])
                    2'd0: begin esz = 1; emax = 15; end
                    2'd1: begin esz = 2; emax = 7;  end
                    2'd2: begin esz = 8; emax = 1;  end
                    default: begin esz = 4; emax = 3; end
                endcase
                if (q.element_code > emax)
                    r.exception_code = vlsu_pkg::EXC_SPEC;
                else
                begin
                    pos = q.element_code * esz;
                    if (!q.mode[3])
                    begin
                        for (int j = 0; j < esz; j++)
                            v[127 - 8*(pos+j) -: 8] = byte_at(mem, j);
                        r.fetch_length = 5'(esz);
                    end
                    else
                    begin
                        st = '0;
                        for (int j = 0; j < esz; j++)
                            st[127 - 8*j -: 8] = byte_at(v, pos + j);
                        {r.store_high, r.store_low} = st;
                        r.store_length = 5'(esz);
                    end
                end
            end
            vlsu_pkg::MODE_VLLEZ:
            begin
                if (q.element_code > 3 && q.element_code != 6)
                    r.exception_code = vlsu_pkg::EXC_SPEC;
                else
                begin
                    len = (q.element_code == 6) ? 4 : (1 << q.element_code);
                    pos = (q.element_code == 6) ? 0 : 8 - len;
                    v   = '0;
                    for (int j = 0; j < len; j++)
                        v[127 - 8*(pos+j) -: 8] = byte_at(mem, j);
                    r.fetch_length = 5'(len);
                end
            end
            vlsu_pkg::MODE_VLREP:
            begin
                if (q.element_code > 3)
                    r.exception_code = vlsu_pkg::EXC_SPEC;
                else
                begin
                    len = 1 << q.element_code;
                    for (int i = 0; i < 16; i++)
                        v[127 - 8*i -: 8] = byte_at(mem, i % len);
                    r.fetch_length = 5'(len);
                end
            end
            vlsu_pkg::MODE_VL:
            begin
                v = mem;
                r.fetch_length = 5'd16;
            end
            vlsu_pkg::MODE_VLBB, vlsu_pkg::MODE_LCBB:
            begin
                if (q.element_code > 6)
                    r.exception_code = vlsu_pkg::EXC_SPEC;
                else
                begin
                    len = bytes_to_boundary(q.element_code, q.address_offset);
                    if (q.mode == vlsu_pkg::MODE_VLBB)
                    begin
                        for (int j = 0; j < len; j++)
                            v[127 - 8*j -: 8] = byte_at(mem, j);
                        r.fetch_length = 5'(len);
                    end
                    else
                    begin
                        r.boundary_count  = 5'(len);
                        r.cond_code       = (len == 16) ? vlsu_pkg::CC_FULL
                                                        : vlsu_pkg::CC_SHORT;
                        r.cond_code_valid = 1'b1;
                    end
                end
            end
            vlsu_pkg::MODE_VST:
            begin
                {r.store_high, r.store_low} = v;
                r.store_length = 5'd16;
            end
            vlsu_pkg::MODE_VGBM:
            begin
                for (int i = 0; i < 16; i++)
                    v[127 - 8*i -: 8] = q.immediate_mask[15 - i] ? 8'hff : 8'h00;
            end
            default:
                v = vreg_model[q.source_a_reg] & vreg_model[q.source_b_reg];
        endcase
        vreg_model[q.target_reg] = v;
        return r;
    endfunction

    function automatic vlsu_pkg::req_t rand_req();
        vlsu_pkg::req_t q;
        q.mode           = 4'($urandom_range(0, 15));
        q.target_reg     = 5'($urandom_range(0, 31));
        q.source_a_reg   = 5'($urandom_range(0, 31));
        q.source_b_reg   = 5'($urandom_range(0, 31));
        // mostly legal codes so that deep behaviour is reached
        q.element_code   = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 6))
                                                     : 4'($urandom_range(0, 15));
        q.address_offset = 12'($urandom);
        q.immediate_mask = 16'($urandom);
        q.memory_high    = {$urandom, $urandom};
        q.memory_low     = {$urandom, $urandom};
        return q;
    endfunction

    function automatic vlsu_pkg::req_t make_req(logic [3:0] mode, logic [4:0] t,
                                                logic [3:0] code, logic [11:0] addr);
        vlsu_pkg::req_t q;
        q = rand_req();
        q.mode           = mode;
        q.target_reg     = t;
        q.element_code   = code;
        q.address_offset = addr;
        return q;
    endfunction

    // driver: push one pending request, random gaps between requests
    int push_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            req_data <= '0;
            push_gap <= 0;
        end
        else if (req_taken)
        begin
            // accepted at the last rising edge
            if (push_gap == 0 && pending_reqs.size() > 1 && gap_len() == 0)
            begin
                void'(pending_reqs.pop_front());
                req_data <= pending_reqs[0];
            end
            else
            begin
                void'(pending_reqs.pop_front());
                push     <= 1'b0;
                push_gap <= gap_len();
            end
        end
        else if (!push)
        begin
            if (push_gap > 0)
                push_gap <= push_gap - 1;
            else if (pending_reqs.size() > 0)
            begin
                req_data <= pending_reqs[0];
                push     <= 1'b1;
            end
        end
    end

    // predictor runs at the accepting edge
    always @(posedge clk)
    begin
        req_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            expected_rsps.push_back(execute_instr(req_data));
            accepted_reqs++;
        end
    end

    // pop side stalls
    int pop_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end
        else if (pop_gap > 0)
        begin
            pop     <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            pop     <= 1'b0;
            pop_gap <= gap_len();
        end
        else
            pop <= 1'b1;
    end

    // monitor: compare each popped result with the oldest expectation
    always @(posedge clk)
    begin
        vlsu_pkg::rsp_t e;
        if (rst_n && pop && !empty)
        begin
            checked_rsps++;
            if (expected_rsps.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (e.exception_code < 3)
                    exc_count[e.exception_code]++;
                if (e.cond_code_valid && e.cond_code == vlsu_pkg::CC_SHORT)
                    lcbb_short++;
                if (rsp_data.store_high !== e.store_high)
                begin
                    $error("store_high exp %h got %h", e.store_high, rsp_data.store_high);
                    errors++;
                end
                if (rsp_data.store_low !== e.store_low)
                begin
                    $error("store_low exp %h got %h", e.store_low, rsp_data.store_low);
                    errors++;
                end
                if (rsp_data.store_length !== e.store_length)
                begin
                    $error("store_length exp %0d got %0d", e.store_length,
                           rsp_data.store_length);
                    errors++;
                end
                if (rsp_data.fetch_length !== e.fetch_length)
                begin
                    $error("fetch_length exp %0d got %0d", e.fetch_length,
                           rsp_data.fetch_length);
                    errors++;
                end
                if (rsp_data.boundary_count !== e.boundary_count)
                begin
                    $error("boundary_count exp %0d got %0d", e.boundary_count,
                           rsp_data.boundary_count);
                    errors++;
                end
                if (rsp_data.cond_code !== e.cond_code)
                begin
                    $error("cond_code exp %0d got %0d", e.cond_code, rsp_data.cond_code);
                    errors++;
                end
                if (rsp_data.cond_code_valid !== e.cond_code_valid)
                begin
                    $error("cond_code_valid exp %0d got %0d", e.cond_code_valid,
                           rsp_data.cond_code_valid);
                    errors++;
                end
                if (rsp_data.exception_code !== e.exception_code)
                begin
                    $error("exception_code exp %0d got %0d", e.exception_code,
                           rsp_data.exception_code);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no request, result or enable write moving
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired: %0d requests left, %0d results due",
                     pending_reqs.size(), expected_rsps.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(logic value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        vec_enabled = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int n);
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(rand_req());
    endtask

    // stimulus
    initial
    begin
        vlsu_pkg::req_t q;
        errors        = 0;
        accepted_reqs = 0;
        checked_rsps  = 0;
        lcbb_short    = 0;
        exc_count     = '{0, 0, 0};
        vec_enabled   = 1'b1;
        for (int r = 0; r < 32; r++)
            vreg_model[r] = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every mode, code extremes, boundaries
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VST, 5'd31, 4'd0, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VL, 5'd0, 4'd15, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLEB, 5'd0, 4'd15, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLEH, 5'd1, 4'd8, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLEG, 5'd1, 4'd1, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLEF, 5'd1, 4'd4, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLLEZ, 5'd2, 4'd6, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLLEZ, 5'd3, 4'd5, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLLEZ, 5'd3, 4'd3, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLREP, 5'd4, 4'd2, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLREP, 5'd4, 4'd4, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLBB, 5'd5, 4'd0, 12'hfff));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VLBB, 5'd5, 4'd7, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_LCBB, 5'd5, 4'd6, 12'hff0));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_LCBB, 5'd5, 4'd6, 12'hff1));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_LCBB, 5'd5, 4'd15, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VSTEB, 5'd0, 4'd15, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VSTEH, 5'd1, 4'd7, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VSTEG, 5'd1, 4'd2, 12'h000));
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VSTEF, 5'd2, 4'd3, 12'h000));
        q = make_req(vlsu_pkg::MODE_VGBM, 5'd6, 4'd0, 12'h000);
        q.immediate_mask = 16'ha5ff;
        pending_reqs.push_back(q);
        q = make_req(vlsu_pkg::MODE_VN, 5'd7, 4'd0, 12'h000);
        q.source_a_reg = 5'd6;
        q.source_b_reg = 5'd0;
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(vlsu_pkg::MODE_VST, 5'd7, 4'd0, 12'h000));
        random_requests(300);
        drain();

        // facility disabled, then back on (the sender waits out each phase)
        write_enable(1'b0);
        random_requests(100);
        drain();
        write_enable(1'b1);
        random_requests(600);
        drain();
        write_enable(1'b0);
        random_requests(40);
        drain();
        write_enable(1'b1);
        random_requests(460);
        drain();

        $display("run: %0d requests, %0d results checked; spec exc %0d, disabled %0d",
                 accepted_reqs, checked_rsps, exc_count[1], exc_count[2]);
        $display("run: short block counts %0d, enable toggled four times", lcbb_short);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
